FILE: hdl/sha256_byte_stream_hasher_defines.svh
// assertion macros for the sha-256 byte stream hasher
// no dependencies
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

`define SHA_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

`define SHA_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

FILE: hdl/sha_pkg.sv
// package for the sha-256 byte stream hasher: types, constants, round functions
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  typedef enum logic [1:0] {
    OP_ABSORB = 2'd0,
    OP_ABSORB_FINISH = 2'd1,
    OP_FINISH = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } core_ctl_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

FILE: hdl/sha_if.sv
// valid/ready channel interfaces for the hasher
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface sha_in_if;
  logic valid;
  logic ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  modport source (output valid, opcode, data_byte, input ready);
  modport sink (input valid, opcode, data_byte, output ready);
endinterface

interface sha_out_if;
  logic valid;
  logic ready;
  logic [31:0] digest_word;
  logic [2:0] word_index;
  logic last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

FILE: hdl/sha_core.sv
// sha-256 compression: one round per cycle through a shared round unit
// depends on sha_pkg
`timescale 1ns / 1ps
`default_nettype none
module sha_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [511:0] block,
  input  wire logic restart,
  output logic busy,
  output logic [255:0] chain
);

  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [31:0] h [8];
  logic [5:0] round_index;
  logic running;
  logic update;
  logic [31:0] wt, t1, t2, ls0, ls1, s0, s1, ch, mj;

  always_comb begin
    ls0 = sha_pkg::ror(w[1], 7) ^ sha_pkg::ror(w[1], 18) ^ (w[1] >> 3);
    ls1 = sha_pkg::ror(w[14], 17) ^ sha_pkg::ror(w[14], 19) ^ (w[14] >> 10);
    wt = (round_index < 6'd16) ? w[0] : (w[0] + ls0 + w[9] + ls1);
    s1 = sha_pkg::ror(v[4], 6) ^ sha_pkg::ror(v[4], 11) ^ sha_pkg::ror(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + s1 + ch + sha_pkg::round_k(round_index) + wt;
    s0 = sha_pkg::ror(v[0], 2) ^ sha_pkg::ror(v[0], 13) ^ sha_pkg::ror(v[0], 22);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = s0 + mj;
  end

  // window rotates so slot 0 holds the current word in rounds 0-15 and the word sixteen back after that
  always_ff @(posedge clk) begin
    if (start && !running) begin
      for (int i = 0; i < 16; i++) w[i] <= block[511 - 32*i -: 32];
      for (int i = 0; i < 8; i++) v[i] <= h[i];
    end else if (running) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wt;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      update <= 1'b0;
      round_index <= '0;
      for (int i = 0; i < 8; i++) h[i] <= sha_pkg::INIT_HASH[i];
    end else begin
      update <= 1'b0;
      if (restart) begin
        for (int i = 0; i < 8; i++) h[i] <= sha_pkg::INIT_HASH[i];
      end else if (update) begin
        for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
      end
      if (start && !running) begin
        running <= 1'b1;
        round_index <= '0;
      end else if (running) begin
        round_index <= round_index + 6'd1;
        if (round_index == 6'd63) begin
          running <= 1'b0;
          update <= 1'b1;
        end
      end
    end
  end

  assign busy = running || update;
  always_comb begin
    for (int i = 0; i < 8; i++) chain[255 - 32*i -: 32] = h[i];
  end

endmodule
`default_nettype wire

FILE: hdl/sha256_byte_stream_hasher.sv
// top level of the sha-256 byte stream hasher: byte buffer, padding, digest output
// depends on sha_pkg, sha_if, sha_core and the defines header
//
//   channel   dir   payload
//   in_ch     in    opcode, data_byte
//   out_ch    out   digest_word, word_index, last_word
//
// an absorbed byte that does not complete a block leaves in_ch ready; a byte completing a block
// starts a compression (64 rounds in the shared round unit, chain update, handoff)
// finish takes one or two block compressions plus eight output items
// synchronous reset loads the initial hash and clears counts
// in_ch is not ready while a compression runs or the digest drains; out_ch may stall
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_byte_stream_hasher_defines.svh"
module sha256_byte_stream_hasher (
  input  wire logic clk,
  input  wire logic rst,
  sha_in_if.sink in_ch,
  sha_out_if.source out_ch
);

  sha_pkg::state_t state, state_next;
  logic [5:0] fill_count;
  logic [63:0] bit_count;
  logic finishing;
  logic second_block;
  logic [2:0] word_index;
  logic [511:0] block;
  logic [511:0] block_next;
  logic core_busy;
  logic [255:0] chain;
  sha_pkg::core_ctl_t ctl;
  logic accept;
  logic has_byte;
  logic do_finish;
  logic [5:0] pos;

  assign accept = in_ch.valid && in_ch.ready;
  assign has_byte = in_ch.opcode == sha_pkg::OP_ABSORB ||
                    in_ch.opcode == sha_pkg::OP_ABSORB_FINISH;
  assign do_finish = in_ch.opcode == sha_pkg::OP_ABSORB_FINISH ||
                     in_ch.opcode == sha_pkg::OP_FINISH;
  assign in_ch.ready = (state == sha_pkg::ST_IDLE);
  assign pos = has_byte ? fill_count + 6'd1 : fill_count;

  sha_core u_core (
    .clk(clk), .rst(rst), .start(ctl.start), .block(block),
    .restart(ctl.done), .busy(core_busy), .chain(chain)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= sha_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    ctl.busy = core_busy;
    unique case (state)
      sha_pkg::ST_IDLE: begin
        if (accept && in_ch.opcode != sha_pkg::OP_UNUSED) begin
          if (has_byte && fill_count == 6'd63) begin
            state_next = sha_pkg::ST_ROUND;
          end else if (do_finish) begin
            state_next = sha_pkg::ST_PAD;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        state_next = sha_pkg::ST_ROUND;
      end
      sha_pkg::ST_ROUND: begin
        ctl.start = 1'b1;
        state_next = sha_pkg::ST_UPDATE;
      end
      sha_pkg::ST_UPDATE: begin
        if (!core_busy) begin
          if (finishing && second_block) state_next = sha_pkg::ST_PAD;
          else if (finishing) state_next = sha_pkg::ST_EMIT;
          else state_next = sha_pkg::ST_IDLE;
        end
      end
      sha_pkg::ST_EMIT: begin
        if (out_ch.ready && word_index == 3'd7) begin
          ctl.done = 1'b1;
          state_next = sha_pkg::ST_IDLE;
        end
      end
      default: state_next = sha_pkg::ST_IDLE;
    endcase
  end

  // buffer fill and padding
  always_comb begin
    block_next = block;
    if (state == sha_pkg::ST_IDLE && accept && in_ch.opcode != sha_pkg::OP_UNUSED) begin
      if (has_byte) block_next[511 - 8*fill_count -: 8] = in_ch.data_byte;
      if (do_finish && !(has_byte && fill_count == 6'd63)) begin
        block_next[511 - 8*pos -: 8] = sha_pkg::PAD_BYTE;
        for (int i = 0; i < 64; i++) begin
          if (i > int'(pos)) block_next[511 - 8*i -: 8] = 8'h00;
        end
      end
    end else if (state == sha_pkg::ST_UPDATE && !core_busy && finishing && second_block) begin
      // previous block ended exactly full or padding overflowed
      block_next = '0;
      if (fill_count == 6'd0) block_next[511 -: 8] = sha_pkg::PAD_BYTE;
    end else if (state == sha_pkg::ST_PAD && !second_block) begin
      block_next[63:0] = bit_count;
    end
  end

  always_ff @(posedge clk) begin
    block <= block_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      bit_count <= '0;
      finishing <= 1'b0;
      second_block <= 1'b0;
      word_index <= '0;
    end else begin
      unique case (state)
        sha_pkg::ST_IDLE: begin
          word_index <= '0;
          if (accept && in_ch.opcode != sha_pkg::OP_UNUSED) begin
            if (has_byte) begin
              fill_count <= fill_count + 6'd1;
              bit_count <= bit_count + 64'd8;
            end
            if (do_finish) begin
              finishing <= 1'b1;
              if (has_byte && fill_count == 6'd63) second_block <= 1'b1;
              else second_block <= pos >= sha_pkg::LEN_POS;
            end
          end
        end
        sha_pkg::ST_UPDATE: begin
          if (!core_busy && finishing && second_block) begin
            second_block <= 1'b0;
          end
        end
        sha_pkg::ST_EMIT: begin
          if (out_ch.ready) begin
            word_index <= word_index + 3'd1;
            if (word_index == 3'd7) begin
              finishing <= 1'b0;
              fill_count <= '0;
              bit_count <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid = (state == sha_pkg::ST_EMIT);
  assign out_ch.digest_word = chain[255 - 32*word_index -: 32];
  assign out_ch.word_index = word_index;
  assign out_ch.last_word = (word_index == 3'd7);

  `SHA_ASSERT_IMPLIES(a_no_ready_busy, clk, rst, ctl.busy, !in_ch.ready)
  `SHA_ASSERT_IMPLIES(a_last_flag, clk, rst, out_ch.valid && out_ch.last_word, word_index == 3'd7)
  `SHA_ASSERT_NEXT(a_emit_hold, clk, rst, out_ch.valid && !out_ch.ready,
    out_ch.valid && $stable(word_index))

endmodule
`default_nettype wire

FILE: bench/tb_sha256_byte_stream_hasher.sv
// testbench for the sha-256 byte stream hasher: random and directed byte streams,
// digests checked against a behavioral sha-256 model; depends on sha_pkg, sha_if and the hasher
`timescale 1ns / 1ps
module tb_sha256_byte_stream_hasher;

  typedef struct {
    sha_pkg::opcode_t op;
    logic [7:0] data;
  } byte_item_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0] idx;
    logic last;
  } digest_item_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RECV_HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  sha_in_if in_ch();
  sha_out_if out_ch();

  sha256_byte_stream_hasher DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  byte_item_t pending_bytes[$];
  digest_item_t expected_digest[$];

  logic [31:0] model_chain[8];
  logic [63:0] model_bits;
  logic [7:0] model_block[64];
  int model_fill;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold_go = 1'b0;
  int recv_hold_left = 0;
  bit stim_done = 1'b0;
  int errors = 0;
  int quiet_cycles = 0;

  const logic [31:0] round_const[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  const logic [31:0] start_hash[8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_model_block();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {model_block[4*i], model_block[4*i+1], model_block[4*i+2], model_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = model_chain[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const[r] + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) model_chain[i] += v[i];
  endtask

  task automatic restart_model();
    for (int i = 0; i < 8; i++) model_chain[i] = start_hash[i];
    model_bits = '0;
    model_fill = 0;
  endtask

  task automatic predict_digest(byte_item_t it);
    int pos;
    digest_item_t d;
    if (it.op == sha_pkg::OP_UNUSED) return;
    if (it.op == sha_pkg::OP_ABSORB || it.op == sha_pkg::OP_ABSORB_FINISH) begin
      model_block[model_fill] = it.data;
      model_bits += 64'd8;
      model_fill = (model_fill + 1) % 64;
      if (model_fill == 0) compress_model_block();
    end
    if (it.op == sha_pkg::OP_ABSORB) return;
    pos = model_fill;
    model_block[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        model_block[pos] = 8'h00;
        pos++;
      end
      compress_model_block();
      pos = 0;
    end
    while (pos < 56) begin
      model_block[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) model_block[56+i] = model_bits[63-8*i -: 8];
    compress_model_block();
    for (int i = 0; i < 8; i++) begin
      d.word = model_chain[i];
      d.idx = 3'(i);
      d.last = (i == 7);
      expected_digest.push_back(d);
    end
    restart_model();
  endtask

  function automatic byte_item_t mk(sha_pkg::opcode_t op, logic [7:0] data);
    byte_item_t it;
    it.op = op;
    it.data = data;
    return it;
  endfunction

  task automatic add_message(int len, bit absorb_finish);
    for (int i = 0; i < len; i++) begin
      if (absorb_finish && i == len - 1)
        pending_bytes.push_back(mk(sha_pkg::OP_ABSORB_FINISH, 8'($urandom)));
      else
        pending_bytes.push_back(mk(sha_pkg::OP_ABSORB, 8'($urandom)));
    end
    if (!absorb_finish || len == 0)
      pending_bytes.push_back(mk(sha_pkg::OP_FINISH, 8'($urandom)));
  endtask

  task automatic random_messages(int n_bytes);
    int sent;
    int len;
    sent = 0;
    while (sent < n_bytes) begin
      case ($urandom_range(0, 5))
        0: len = $urandom_range(54, 66);
        1: len = 0;
        default: len = $urandom_range(1, 40);
      endcase
      if ($urandom_range(0, 9) == 0)
        pending_bytes.push_back(mk(sha_pkg::OP_UNUSED, 8'($urandom)));
      add_message(len, 1'($urandom_range(0, 1)));
      sent += len + 1;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_bytes.size() != 0 || in_ch.valid || expected_digest.size() != 0)
      @(negedge clk);
    repeat (200) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.opcode <= sha_pkg::OP_ABSORB;
      in_ch.data_byte <= 8'h00;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) predict_digest(mk(sha_pkg::opcode_t'(in_ch.opcode), in_ch.data_byte));
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        byte_item_t it;
        it = pending_bytes.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.opcode <= it.op;
        in_ch.data_byte <= it.data;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver hold counter
  always @(posedge clk) begin
    if (recv_hold_go) recv_hold_left <= RECV_HOLD_CYCLES;
    else if (recv_hold_left != 0) recv_hold_left <= recv_hold_left - 1;
  end

  // monitor and receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_digest.size() == 0) begin
          $display("%0t: unexpected digest item word=%h idx=%0d last=%b", $time,
                   out_ch.digest_word, out_ch.word_index, out_ch.last_word);
          errors++;
        end else begin
          digest_item_t e;
          e = expected_digest.pop_front();
          if (out_ch.digest_word !== e.word || out_ch.word_index !== e.idx ||
              out_ch.last_word !== e.last) begin
            $display("%0t: mismatch exp word=%h idx=%0d last=%b act word=%h idx=%0d last=%b",
                     $time, e.word, e.idx, e.last,
                     out_ch.digest_word, out_ch.word_index, out_ch.last_word);
            errors++;
          end
        end
      end
      out_ch.ready <= (recv_hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else if (!stim_done)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    restart_model();
    for (int i = 0; i < 64; i++) model_block[i] = 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty message, extremes, opcodes, padding boundaries
    add_message(0, 1'b0);
    pending_bytes.push_back(mk(sha_pkg::OP_ABSORB, 8'h00));
    pending_bytes.push_back(mk(sha_pkg::OP_ABSORB, 8'hff));
    pending_bytes.push_back(mk(sha_pkg::OP_UNUSED, 8'hff));
    pending_bytes.push_back(mk(sha_pkg::OP_ABSORB_FINISH, 8'h55));
    pending_bytes.push_back(mk(sha_pkg::OP_ABSORB_FINISH, 8'haa));
    pending_bytes.push_back(mk(sha_pkg::OP_FINISH, 8'hff));
    add_message(3, 1'b1);
    wait_drained();
    add_message(55, 1'b0);
    add_message(56, 1'b1);
    add_message(64, 1'b1);
    wait_drained();

    random_messages(10);
    wait_drained();
    send_idle_pct = 73;
    random_messages(10);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 73;
    random_messages(10);
    wait_drained();
    send_idle_pct = 29;
    recv_stall_pct = 29;
    random_messages(10);
    // receiver holds off while items keep coming
    recv_hold_go <= 1'b1;
    @(posedge clk);
    recv_hold_go <= 1'b0;
    @(posedge clk);
    while (recv_hold_left != 0) @(posedge clk);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // sender pauses until every digest has drained
    add_message(10, 1'b1);
    wait_drained();
    random_messages(10);
    wait_drained();
    stim_done = 1'b1;

    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/sha_pkg.sv
hdl/sha_if.sv
hdl/sha_core.sv
hdl/sha256_byte_stream_hasher.sv
bench/tb_sha256_byte_stream_hasher.sv
